FILE: rtl/gdd_pkg.sv
// Shared widths, calendar tables and pipeline control type for the date difference unit.
`timescale 1ns / 1ps

package gdd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int DAYNUM_W = 23;
   localparam int MBASE_W  = 9;
   localparam int Q100_W   = 8;
   localparam int PROD_W   = 27;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 43699
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } gdd_adv_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [MBASE_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [MBASE_W-1:0] n;
      unique case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/gregorian_date_difference_unit.sv
// Top level: days between two Gregorian dates, four-stage pipeline with per-stage stall.
// An accepted req beat goes through stage 1, 2 and 3 registers and the count register.
// Throughput: one beat per cycle; a stalled rsp only holds the stages it blocks.
// Bubbles collapse: req is taken while a done result waits on rsp if a stage is free.
// Reset clears the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module gregorian_date_difference_unit
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [YEAR_W-1:0]  req_end_year,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic               req_include_end_day,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_day_count,
   output logic               rsp_status
);

   gdd_adv_type adv;
   logic        adv1, adv2, adv3, adv4;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        inc1_ff, inc2_ff, inc3_ff;

   logic [DAYNUM_W-1:0] a_num, b_num;
   logic                a_ok, b_ok;

   logic [DAYNUM_W:0]   sum;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                status_ff, status_in;

   assign adv4      = !v4_ff || !rsp_stall;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign adv       = '{s1: adv1, s2: adv2, s3: adv3};
   assign req_stall = !adv1;

   gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_start (
      .clock   (clock),
      .adv     (adv),
      .year    (req_start_year),
      .month   (req_start_month),
      .day     (req_start_day),
      .day_num (a_num),
      .date_ok (a_ok)
   );

   gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_end (
      .clock   (clock),
      .adv     (adv),
      .year    (req_end_year),
      .month   (req_end_month),
      .day     (req_end_day),
      .day_num (b_num),
      .date_ok (b_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) inc1_ff <= req_include_end_day;
      if (adv2) inc2_ff <= inc1_ff;
      if (adv3) inc3_ff <= inc2_ff;
   end

   always_comb begin
      sum = (DAYNUM_W + 1)'(inc3_ff);
      if (a_num < b_num) begin
         sum = (DAYNUM_W + 1)'(b_num - a_num) + (DAYNUM_W + 1)'(inc3_ff);
      end
      if (!(a_ok && b_ok)) begin
         count_in  = '0;
         status_in = STATUS_INVALID;
      end else begin
         count_in  = (sum > (DAYNUM_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_day_count = count_ff;
   assign rsp_status    = status_ff;

endmodule

FILE: rtl/gdd_day_number.sv
// Three-stage pipeline that checks one date and computes its day number from 0001-01-01.
`timescale 1ns / 1ps

module gdd_day_number
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic                clock,
   input  gdd_adv_type         adv,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   output logic [DAYNUM_W-1:0] day_num,
   output logic                date_ok
);

   localparam logic [YEAR_W:0] MAX_YEAR_C = (YEAR_W + 1)'(MAX_YEAR);

   // stage 1
   logic [YEAR_W-1:0]  y_ff, y_in;
   logic [YEAR_W-1:0]  p_ff, p_in;
   logic [Q100_W-1:0]  qy_ff, qy_in;
   logic [Q100_W-1:0]  qp_ff, qp_in;
   logic [MBASE_W-1:0] mbase1_ff, mbase1_in;
   logic [DAY_W-1:0]   mlen_ff, mlen_in;
   logic [DAY_W-1:0]   d_ff;
   logic               feb_ff, feb_in;
   logic               after_feb_ff, after_feb_in;
   logic               ok1_ff, ok1_in;
   logic [PROD_W-1:0]  prod_y, prod_p;

   // stage 2
   logic [DAYNUM_W-1:0] ypart_ff, ypart_in;
   logic [MBASE_W-1:0]  mbase2_ff, mbase2_in;
   logic                ok2_ff, ok2_in;
   logic [YEAR_W:0]     y100;
   logic                leap;
   logic [DAY_W-1:0]    len;

   // stage 3
   logic [DAYNUM_W-1:0] num_ff, num_in;
   logic                ok3_ff;

   always_comb begin
      p_in         = year - YEAR_W'(1);
      prod_y       = PROD_W'(year) * PROD_W'(RECIP_100);
      prod_p       = PROD_W'(p_in) * PROD_W'(RECIP_100);
      qy_in        = prod_y[RECIP_SHIFT +: Q100_W];
      qp_in        = prod_p[RECIP_SHIFT +: Q100_W];
      y_in         = year;
      mbase1_in    = days_before(month) + MBASE_W'(day);
      mlen_in      = month_len(month);
      feb_in       = (month == MONTH_FEB);
      after_feb_in = (month > MONTH_FEB);
      ok1_in       = (year != '0) && ({1'b0, year} <= MAX_YEAR_C)
                     && (month >= MONTH_JAN) && (month <= MONTH_DEC) && (day != '0);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         y_ff         <= y_in;
         p_ff         <= p_in;
         qy_ff        <= qy_in;
         qp_ff        <= qp_in;
         mbase1_ff    <= mbase1_in;
         mlen_ff      <= mlen_in;
         d_ff         <= day;
         feb_ff       <= feb_in;
         after_feb_ff <= after_feb_in;
         ok1_ff       <= ok1_in;
      end
   end

   always_comb begin
      y100      = (YEAR_W + 1)'(qy_ff) * (YEAR_W + 1)'(100);
      leap      = (y_ff[1:0] == 2'b00) && (({1'b0, y_ff} != y100) || (qy_ff[1:0] == 2'b00));
      len       = mlen_ff + DAY_W'(feb_ff && leap);
      ok2_in    = ok1_ff && (d_ff <= len);
      ypart_in  = DAYNUM_W'(p_ff) * DAYNUM_W'(365)
                  + DAYNUM_W'(p_ff >> 2)
                  - DAYNUM_W'(qp_ff)
                  + DAYNUM_W'(qp_ff >> 2);
      mbase2_in = mbase1_ff + MBASE_W'(after_feb_ff && leap);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         ypart_ff  <= ypart_in;
         mbase2_ff <= mbase2_in;
         ok2_ff    <= ok2_in;
      end
   end

   assign num_in = ypart_ff + DAYNUM_W'(mbase2_ff);

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         num_ff <= num_in;
         ok3_ff <= ok2_ff;
      end
   end

   assign day_num = num_ff;
   assign date_ok = ok3_ff;

endmodule
